FILE: hw/rtl/gelu_pkg.sv
// Shared types, constants and single-precision arithmetic helpers for the bfloat16 GELU pipeline.
package gelu_pkg;

	// Latency from an accepted start to the done strobe, in clock cycles.
	localparam int PIPE_LAT = 31;

	localparam logic [31:0] C_SQ2PI = 32'h3F4C422A;  // 0.79788456
	localparam logic [31:0] C_BETA  = 32'h3D372713;  // 0.044715
	localparam logic [31:0] C_27    = 32'h41D80000;
	localparam logic [31:0] C_9     = 32'h41100000;
	localparam logic [31:0] C_HALF  = 32'h3F000000;
	localparam logic [31:0] C_ONE   = 32'h3F800000;
	localparam logic [31:0] C_MONE  = 32'hBF800000;
	localparam logic [31:0] C_TBIG  = 32'h45800000;  // 4096.0
	localparam logic [31:0] F_QNAN  = 32'h7FC00000;

	localparam logic [15:0] BF_NINF   = 16'hFF80;
	localparam logic [15:0] BF_DEFNAN = 16'hFFC0;
	localparam logic [15:0] BF_QBIT   = 16'h0040;

	// Unrounded result: value is man[49].man[48:0] * 2^(expo-127).
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sgn;
		logic signed [11:0] expo;
		logic [49:0]        man;
	} fpu_t;

	// State of the restoring divider as it moves down the pipeline.
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sgn;
		logic signed [11:0] expo;
		logic [24:0]        rem;
		logic [27:0]        quo;
		logic [23:0]        dm;
	} div_t;

	// Values carried beside the arithmetic: the input and two reused intermediates.
	typedef struct packed {
		logic [15:0] x;
		logic [31:0] t;
		logic [31:0] h;
	} side_t;

	function automatic logic [5:0] lzc52(input logic [51:0] v);
		logic [5:0] n;
		n = 6'd52;
		for (int i = 0; i < 52; i++) begin
			if (v[i]) begin
				n = 6'(51 - i);
			end
		end
		return n;
	endfunction

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic [7:0] eff_exp(input logic [31:0] a);
		return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
	endfunction

	function automatic logic [23:0] full_man(input logic [31:0] a);
		return {a[30:23] != 8'd0, a[22:0]};
	endfunction

	// Exact product, normalized so that the leading one sits at the top.
	function automatic fpu_t fmul_core(input logic [31:0] a, input logic [31:0] b);
		logic [47:0] p;
		logic [47:0] pn;
		logic [5:0]  lz;
		fpu_t        r;
		p      = full_man(a) * full_man(b);
		lz     = lzc52({p, 4'd0});
		pn     = p << lz;
		r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && (b[30:0] == 31'd0)) ||
			((a[30:0] == 31'd0) && is_inf(b));
		r.inf  = is_inf(a) || is_inf(b);
		r.zero = (p == 48'd0);
		r.sgn  = a[31] ^ b[31];
		r.expo = {4'd0, eff_exp(a)} + {4'd0, eff_exp(b)} - {6'd0, lz} - 12'd126;
		r.man  = {pn, 2'b00};
		return r;
	endfunction

	// Aligned sum with a sticky bit folded into the lowest position.
	function automatic fpu_t fadd_core(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] bg;
		logic [31:0] sm;
		logic [7:0]  d;
		logic [51:0] fa;
		logic [51:0] fb0;
		logic [51:0] fb;
		logic [51:0] lost;
		logic [51:0] s;
		logic [51:0] sn;
		logic [5:0]  lz;
		logic        sub;
		fpu_t        r;
		if (a[30:0] >= b[30:0]) begin
			bg = a;
			sm = b;
		end else begin
			bg = b;
			sm = a;
		end
		sub = bg[31] ^ sm[31];
		d   = eff_exp(bg) - eff_exp(sm);
		fa  = {1'b0, full_man(bg), 27'd0};
		fb0 = {1'b0, full_man(sm), 27'd0};
		if (d >= 8'd52) begin
			fb = {51'd0, |full_man(sm)};
		end else begin
			lost = fb0 & ~({52{1'b1}} << d);
			fb   = (fb0 >> d) | {51'd0, |lost};
		end
		s      = sub ? (fa - fb) : (fa + fb);
		lz     = lzc52(s);
		sn     = s << lz;
		r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && sub);
		r.inf  = is_inf(a) || is_inf(b);
		r.zero = (s == 52'd0);
		// An exact cancellation gives +0; two zeros of one sign keep it.
		r.sgn  = r.zero ? (bg[31] & ~sub) : bg[31];
		r.expo = {4'd0, eff_exp(bg)} + 12'd1 - {6'd0, lz};
		r.man  = {sn[51:3], |sn[2:0]};
		return r;
	endfunction

	// Round to nearest even, with gradual underflow and overflow to infinity.
	function automatic logic [31:0] fround(input fpu_t u);
		logic [49:0] m;
		logic [11:0] sh;
		logic [7:0]  ef;
		logic [30:0] bits;
		logic        inc;
		logic [31:0] r;
		m  = u.man;
		ef = u.expo[7:0];
		sh = 12'd1 - u.expo;
		if (u.expo < 12'sd1) begin
			ef = 8'd0;
			if (sh >= 12'd50) begin
				m = {49'd0, |u.man};
			end else begin
				m = (u.man >> sh[5:0]) | {49'd0, |(u.man & ~({50{1'b1}} << sh[5:0]))};
			end
		end
		inc  = m[25] & ((|m[24:0]) | m[26]);
		// A carry out of the fraction steps the exponent field, up to infinity.
		bits = {ef, m[48:26]} + {30'd0, inc};
		if (u.nan) begin
			r = F_QNAN;
		end else if (u.inf || (u.expo >= 12'sd255)) begin
			r = {u.sgn, 8'hFF, 23'd0};
		end else if (u.zero) begin
			r = {u.sgn, 31'd0};
		end else begin
			r = {u.sgn, bits};
		end
		return r;
	endfunction

	function automatic div_t div_start(input logic [31:0] n, input logic [31:0] d);
		logic [23:0] mn0;
		logic [23:0] md0;
		logic [5:0]  ln;
		logic [5:0]  ld;
		div_t        r;
		mn0    = full_man(n);
		md0    = full_man(d);
		ln     = lzc52({mn0, 28'd0});
		ld     = lzc52({md0, 28'd0});
		r.nan  = is_nan(n) || is_nan(d) || (is_inf(n) && is_inf(d)) ||
			((n[30:0] == 31'd0) && (d[30:0] == 31'd0));
		r.inf  = is_inf(n) || (d[30:0] == 31'd0);
		r.zero = (n[30:0] == 31'd0) || is_inf(d);
		r.sgn  = n[31] ^ d[31];
		r.expo = {4'd0, eff_exp(n)} - {6'd0, ln} - {4'd0, eff_exp(d)} + {6'd0, ld} + 12'd127;
		r.rem  = {1'b0, mn0 << ln};
		r.quo  = 28'd0;
		r.dm   = md0 << ld;
		return r;
	endfunction

	// Four restoring quotient bits.
	function automatic div_t div_step4(input div_t v);
		div_t r;
		r = v;
		for (int i = 0; i < 4; i++) begin
			if (r.rem >= {1'b0, r.dm}) begin
				r.rem = r.rem - {1'b0, r.dm};
				r.quo = {r.quo[26:0], 1'b1};
			end else begin
				r.quo = {r.quo[26:0], 1'b0};
			end
			r.rem = r.rem << 1;
		end
		return r;
	endfunction

	function automatic fpu_t div_finish(input div_t v);
		logic st;
		fpu_t r;
		st     = (v.rem != 25'd0);
		r.nan  = v.nan;
		r.inf  = v.inf;
		r.zero = v.zero;
		r.sgn  = v.sgn;
		if (v.quo[27]) begin
			r.man  = {v.quo, st, 21'd0};
			r.expo = v.expo;
		end else begin
			r.man  = {v.quo[26:0], st, 22'd0};
			r.expo = v.expo - 12'sd1;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/bf16_gelu_tanh_rational.sv
// GELU with a rational tanh, bfloat16 in and out, as a fully pipelined datapath.
//
// Usage: drive x_bits (a raw bfloat16 pattern) and raise start; the beat is taken on
// any rising edge with start high, since busy stays low and the pipeline takes one
// beat every cycle. The result appears on y_bits with done high for exactly one cycle,
// once the beat has passed through every stage; done and y_bits are registered together.
// Throughput is one beat per cycle; each single-precision multiply or add occupies
// two stages (exact product or aligned sum, then normalize and round), and the
// divide of the rational tanh is a restoring divider spread over seven stages of
// four quotient bits each, plus a setup and a finishing stage.
// Valid bits travel down the pipeline with the data and are cleared by reset, so
// no done strobe appears until beats are taken after reset. Beats are independent
// and results come out in the order the beats went in. There is no output stall:
// the receiver takes every result in the cycle it is shown.
module bf16_gelu_tanh_rational
	import gelu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] x_bits,
	output logic        done,
	output logic [15:0] y_bits
);

	logic [PIPE_LAT-1:1] vld_s;
	side_t               sd_s [1:PIPE_LAT-1];

	fpu_t        mc_s1, mc_s3, mc_s5, mc_s7, mc_s9, hc_s9, mc_s11, mc_s13, wc_s13;
	fpu_t        mc_s15, dc_s15, mc_s25, mc_s27, mc_s29;
	logic [31:0] v_s2, v_s4, v_s6, v_s8, v_s12, u_s14, w_s14, n_s16, d_s16;
	logic [31:0] th_s26, a_s28, y_s30;
	div_t        dv_s [0:7];

	logic [31:0] th_cl;
	logic [31:0] t26;
	logic        t_big;
	logic [15:0] x30;
	logic [31:0] y_rnd;
	logic [15:0] y_nx;

	assign busy = 1'b0;

	// Clamp of the rational tanh; a very large argument takes the sign of t directly.
	always_comb begin
		t26   = sd_s[26].t;
		t_big = (t26[30:0] > C_TBIG[30:0]) && !is_nan(t26);
		th_cl = th_s26;
		if (t_big) begin
			th_cl = t26[31] ? C_MONE : C_ONE;
		end else if (!is_nan(th_s26) && (th_s26[30:0] > C_ONE[30:0])) begin
			th_cl = th_s26[31] ? C_MONE : C_ONE;
		end
	end

	// Narrowing to bfloat16; NaN inputs come back quieted, and minus infinity gives NaN.
	always_comb begin
		x30   = sd_s[30].x;
		y_rnd = y_s30 + 32'h0000_7FFF + {31'd0, y_s30[16]};
		if ((x30[14:7] == 8'hFF) && (x30[6:0] != 7'd0)) begin
			y_nx = x30 | BF_QBIT;
		end else if (x30 == BF_NINF) begin
			y_nx = BF_DEFNAN;
		end else if (is_nan(y_s30)) begin
			y_nx = y_s30[31:16] | BF_QBIT;
		end else begin
			y_nx = y_rnd[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[PIPE_LAT-2:1], start & ~busy};
			done  <= vld_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		sd_s[1].x <= x_bits;
		sd_s[1].t <= 32'd0;
		sd_s[1].h <= 32'd0;
		for (int k = 2; k < PIPE_LAT; k++) begin
			if (k != 10) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
		// Stage ten picks up t and 0.5*x as they leave their rounding stage.
		sd_s[10].x <= sd_s[9].x;
		sd_s[10].t <= fround(mc_s9);
		sd_s[10].h <= fround(hc_s9);

		mc_s1  <= fmul_core({x_bits, 16'd0}, {x_bits, 16'd0});
		v_s2   <= fround(mc_s1);
		mc_s3  <= fmul_core({sd_s[2].x, 16'd0}, v_s2);
		v_s4   <= fround(mc_s3);
		mc_s5  <= fmul_core(C_BETA, v_s4);
		v_s6   <= fround(mc_s5);
		mc_s7  <= fadd_core({sd_s[6].x, 16'd0}, v_s6);
		v_s8   <= fround(mc_s7);
		mc_s9  <= fmul_core(C_SQ2PI, v_s8);
		hc_s9  <= fmul_core(C_HALF, {sd_s[8].x, 16'd0});
		mc_s11 <= fmul_core(sd_s[10].t, sd_s[10].t);
		v_s12  <= fround(mc_s11);
		mc_s13 <= fadd_core(C_27, v_s12);
		wc_s13 <= fmul_core(C_9, v_s12);
		u_s14  <= fround(mc_s13);
		w_s14  <= fround(wc_s13);
		mc_s15 <= fmul_core(sd_s[14].t, u_s14);
		dc_s15 <= fadd_core(C_27, w_s14);
		n_s16  <= fround(mc_s15);
		d_s16  <= fround(dc_s15);
		dv_s[0] <= div_start(n_s16, d_s16);
		for (int k = 1; k < 8; k++) begin
			dv_s[k] <= div_step4(dv_s[k-1]);
		end
		mc_s25 <= div_finish(dv_s[7]);
		th_s26 <= fround(mc_s25);
		mc_s27 <= fadd_core(C_ONE, th_cl);
		a_s28  <= fround(mc_s27);
		mc_s29 <= fmul_core(sd_s[28].h, a_s28);
		y_s30  <= fround(mc_s29);
		y_bits <= y_nx;
	end

	// A result only ever follows a beat taken exactly one latency earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_LAT))
		else $error("done without a matching start");

	// A NaN input comes back as the same pattern with the quiet bit set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(x_bits[14:7], PIPE_LAT) == 8'hFF) &&
		($past(x_bits[6:0], PIPE_LAT) != 7'd0))
		|-> (y_bits == ($past(x_bits, PIPE_LAT) | BF_QBIT)))
		else $error("NaN input not propagated");

	// Positive zero in gives positive zero out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(x_bits, PIPE_LAT) == 16'h0000)) |-> (y_bits == 16'h0000))
		else $error("zero input gave nonzero result");

endmodule

FILE: test/tb_bf16_gelu_tanh_rational.sv
// Testbench for the bfloat16 GELU pipeline: directed and random inputs against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_bf16_gelu_tanh_rational;
	import gelu_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] x_bits;
	logic        done;
	logic [15:0] y_bits;

	logic [15:0] gelu_pending[$];
	int          mismatches;
	int          beats_sent;
	int          results_seen;
	int          cycle_count;
	bit          no_idle;

	bf16_gelu_tanh_rational DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.x_bits(x_bits),
		.done  (done),
		.y_bits(y_bits)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Single-precision pattern to a real; every float is exact as a double.
	function automatic real sp_to_real(input logic [31:0] f);
		logic [63:0] d;
		real         r;
		if (f[30:23] == 8'hFF) begin
			d = {f[31], 11'h7FF, f[22:0], 29'd0};
		end else if (f[30:23] == 8'd0) begin
			if (f[22:0] == 23'd0) begin
				d = {f[31], 63'd0};
			end else begin
				r = $itor(f[22:0]) * (2.0 ** (-149));
				return f[31] ? -r : r;
			end
		end else begin
			d = {f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	// Round a double to single precision, nearest even, with gradual underflow.
	// A double holds every sum, product or quotient of two floats closely enough
	// that this second rounding matches a direct single-precision operation.
	function automatic logic [31:0] real_to_sp(input real v);
		logic [63:0] d;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rm;
		logic [63:0] hf;
		int          e;
		int          sh;
		d = $realtobits(v);
		if (d[62:52] == 11'h7FF) begin
			return (d[51:0] != 52'd0) ? F_QNAN : {d[63], 8'hFF, 23'd0};
		end
		if (d[62:52] == 11'd0) begin
			return {d[63], 31'd0};
		end
		m  = {11'd0, 1'b1, d[51:0]};
		e  = int'(d[62:52]) - 1023;
		sh = (e >= -126) ? 29 : 29 + (-126 - e);
		if (sh > 62) begin
			q = 64'd0;
		end else begin
			q  = m >> sh;
			rm = m & ((64'd1 << sh) - 64'd1);
			hf = 64'd1 << (sh - 1);
			if ((rm > hf) || ((rm == hf) && q[0])) begin
				q = q + 64'd1;
			end
		end
		if (e >= -126) begin
			if (e + 127 >= 255) begin
				return {d[63], 8'hFF, 23'd0};
			end
			// The hidden bit adds one to the exponent field, and a rounding carry steps it.
			q = q + (64'(e + 126) << 23);
			if (q >= 64'h7F800000) begin
				return {d[63], 8'hFF, 23'd0};
			end
		end
		return {d[63], q[30:0]};
	endfunction

	function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
		return real_to_sp(sp_to_real(a) * sp_to_real(b));
	endfunction

	function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
		return real_to_sp(sp_to_real(a) + sp_to_real(b));
	endfunction

	function automatic logic [31:0] sp_div(input logic [31:0] a, input logic [31:0] b);
		return real_to_sp(sp_to_real(a) / sp_to_real(b));
	endfunction

	function automatic logic bf_is_nan(input logic [15:0] b);
		return (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
	endfunction

	function automatic logic [15:0] predict_gelu(input logic [15:0] xb);
		logic [31:0] x;
		logic [31:0] t;
		logic [31:0] t2;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] th;
		logic [31:0] y;
		x = {xb, 16'd0};
		if (bf_is_nan(xb)) begin
			return xb | BF_QBIT;
		end
		t = sp_mul(C_SQ2PI, sp_add(x, sp_mul(C_BETA, sp_mul(x, sp_mul(x, x)))));
		if (sp_to_real(t) > 4096.0) begin
			th = C_ONE;
		end else if (sp_to_real(t) < -4096.0) begin
			th = C_MONE;
		end else begin
			t2  = sp_mul(t, t);
			num = sp_mul(t, sp_add(C_27, t2));
			den = sp_add(C_27, sp_mul(C_9, t2));
			th  = sp_div(num, den);
			if (sp_to_real(th) > 1.0) begin
				th = C_ONE;
			end else if (sp_to_real(th) < -1.0) begin
				th = C_MONE;
			end
		end
		y = sp_mul(sp_mul(C_HALF, x), sp_add(C_ONE, th));
		if ((y[30:23] == 8'hFF) && (y[22:0] != 23'd0)) begin
			return y[31:16] | BF_QBIT;
		end
		y = y + 32'h7FFF + {31'd0, y[16]};
		return y[31:16];
	endfunction

	// Result checker and run watchdog. The sign and payload of a NaN are not
	// pinned down by the arithmetic, so only a quiet NaN is demanded there.
	always @(posedge clk) begin
		logic [15:0] want;
		logic        ok;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				gelu_pending.size());
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (gelu_pending.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) begin
					$display("unexpected result beat y_bits=%h", y_bits);
				end
			end else begin
				want = gelu_pending.pop_front();
				ok   = bf_is_nan(want) ? (bf_is_nan(y_bits) && y_bits[6]) : (y_bits == want);
				if (!ok) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) begin
						$display("y_bits mismatch: expected %h got %h", want, y_bits);
					end
				end
			end
		end
	end

	// Offers one beat; start stays high afterward, so back-to-back beats need no fresh rise of start.
	task automatic send_x(input logic [15:0] xb);
		int gap;
		if (!no_idle && ($urandom_range(99) < 13)) begin
			gap = $urandom_range(2, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		x_bits <= xb;
		forever begin
			@(negedge clk);
			if (!busy) begin
				break;
			end
		end
		@(posedge clk);
		gelu_pending.push_back(predict_gelu(xb));
		beats_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (gelu_pending.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_directed();
		logic [15:0] vec[$];
		// Zeros, infinities, NaNs, subnormals, the largest finite values, and the
		// regions where the tanh clamps, saturates, or the result collapses to zero.
		vec = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'hFFC0, 16'h7F81,
			16'h0001, 16'h807F, 16'h7F7F, 16'hFF7F, 16'h3F80, 16'hBF80, 16'h4040,
			16'hC040, 16'hC100, 16'hC2C8, 16'h4600, 16'hC600, 16'h3C00, 16'hBC00,
			16'h0080, 16'hFFFF, 16'h5555, 16'hAAAA};
		foreach (vec[i]) begin
			send_x(vec[i]);
		end
		drain_results();
	endtask

	task automatic test_random_patterns(input int n);
		repeat (n) begin
			send_x(16'($urandom_range(16'hFFFF)));
		end
		drain_results();
	endtask

	// Magnitudes from about 2^-15 to just under 2^8, where the rational tanh does its real work.
	task automatic test_active_range(input int n);
		logic [15:0] xb;
		int          k;
		k = 0;
		repeat (n) begin
			no_idle = (k < n / 3);
			xb      = {1'($urandom_range(1)), 8'($urandom_range(8'h86, 8'h70)),
				7'($urandom_range(127))};
			send_x(xb);
			k++;
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		x_bits       = 16'd0;
		mismatches   = 0;
		beats_sent   = 0;
		results_seen = 0;
		cycle_count  = 0;
		no_idle      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_patterns(150);
		test_active_range(300);

		repeat (PIPE_LAT + 10) @(posedge clk);
		$display("%0d beats sent, %0d results checked: special values, full-range",
			beats_sent, results_seen);
		$display("random patterns, and the active range with and without gaps");
		if ((mismatches == 0) && (gelu_pending.size() == 0)) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, gelu_pending.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/gelu_pkg.sv
hw/rtl/bf16_gelu_tanh_rational.sv
test/tb_bf16_gelu_tanh_rational.sv
